FILE: sv/sli_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list package
// Shared sizes, codes and types of the sorted insertion list.
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

  localparam int unsigned LIST_DEPTH  = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int unsigned STATUS_W    = 2;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Write port of the entry memory.
  typedef struct packed {
    logic                   en;
    logic [IDX_W-1:0]       addr;
    logic [VALUE_WIDTH-1:0] data;
  } sli_wr_t;

  // Read port of the entry memory.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } sli_rd_t;

endpackage

`default_nettype wire

FILE: sv/sorted_list_insert_remove_core.sv
// ----------------------------------------------------------------------------
// Sorted list insert/remove core
// Ordered list of signed values kept in a small memory, with insert and
// remove operations and one status result per operation.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                                   Direction  Handshake
//   -------  ----------------------------------------  ---------  ----------
//   in       kind_i, value_i                           input      valid/ready
//   out      status_o, position_o, entry_count_o,      output     valid/ready
//            is_full_o, is_empty_o
//   cfg      cfg_wdata_i (order mode)                  input      write enable
//
// An operation walks the stored entries, so its length grows with the
// entry count, and then registers its result; the next input transfer is
// taken only once the core is back in idle. The single read port of the
// entry memory sets the pace: the list is walked one entry per cycle, and
// the shift is folded into that same walk. An insert into a full list skips
// the walk. Reset clears the count, the order mode and the control state;
// the memory is never cleared. A stalled result holds the next operation
// back at its final step, but the result register lets the core start the
// next walk while the previous result still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_remove_core import sli_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire logic                   kind_i,
  input  wire logic signed [VALUE_WIDTH-1:0] value_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      logic [STATUS_W-1:0]    status_o,
  output      logic [CNT_W-1:0]       position_o,
  output      logic [CNT_W-1:0]       entry_count_o,
  output      logic                   is_full_o,
  output      logic                   is_empty_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Operation being worked on.
  logic                   kind_q;
  logic [VALUE_WIDTH-1:0] value_q;

  // Walk control: next address to read, and the index of the data that
  // comes back from the memory in this cycle.
  logic [CNT_W-1:0]       rd_idx_q, rd_idx_d;
  logic                   rvalid_q, rvalid_d;
  logic [IDX_W-1:0]       pidx_q, pidx_d;

  // Match tracking and the value displaced by an insert.
  logic                   found_q, found_d;
  logic [IDX_W-1:0]       pos_q, pos_d;
  logic [VALUE_WIDTH-1:0] carry_q, carry_d;

  logic [CNT_W-1:0]       count_q, count_d;
  logic                   order_mode_q;

  // Result register.
  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    status_q, status_d;
  logic [CNT_W-1:0]       position_q, position_d;

  sli_wr_t                wr;
  sli_rd_t                rd;
  logic [VALUE_WIDTH-1:0] rd_data;

  logic                   in_xfer;
  logic                   out_free;
  logic                   list_full;
  logic                   insert_here;
  logic                   more_to_read;

  sli_ram u_ram (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_i     (rd),
    .rd_data_o(rd_data)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign list_full  = (count_q == CNT_W'(LIST_DEPTH));
  assign more_to_read = (rd_idx_q < count_q);

  // Order predicate on the entry that the memory returns this cycle. In
  // ascending mode a new value goes before the first larger entry, in
  // descending mode before the first smaller one; equal entries keep it after.
  assign insert_here = order_mode_q ? ($signed(rd_data) < $signed(value_q))
                                    : ($signed(rd_data) > $signed(value_q));

  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    rvalid_d    = 1'b0;
    pidx_d      = pidx_q;
    found_d     = found_q;
    pos_d       = pos_q;
    carry_d     = carry_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    position_d  = position_q;
    wr          = '0;
    rd          = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          rd_idx_d = '0;
          found_d  = 1'b0;
          // A full list refuses an insert without walking it.
          if (kind_i == KIND_INSERT && list_full) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read while the previous entry is processed. Writes
        // always land on an index at or below the one just read, so a read
        // never meets an entry that this walk has already rewritten.
        if (more_to_read) begin
          rd.en    = 1'b1;
          rd.addr  = rd_idx_q[IDX_W-1:0];
          rvalid_d = 1'b1;
          pidx_d   = rd_idx_q[IDX_W-1:0];
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end

        if (rvalid_q) begin
          if (kind_q == KIND_INSERT) begin
            // Past the insert point every entry moves up one place; the
            // displaced value rides along in the carry register.
            if (found_q) begin
              wr      = '{en: 1'b1, addr: pidx_q, data: carry_q};
              carry_d = rd_data;
            end else if (insert_here) begin
              found_d = 1'b1;
              pos_d   = pidx_q;
              wr      = '{en: 1'b1, addr: pidx_q, data: value_q};
              carry_d = rd_data;
            end
          end else begin
            // Past the removed entry every entry moves down one place.
            if (found_q) begin
              wr = '{en: 1'b1, addr: pidx_q - IDX_W'(1), data: rd_data};
            end else if (rd_data == value_q) begin
              found_d = 1'b1;
              pos_d   = pidx_q;
            end
          end
        end

        if (!more_to_read && !rvalid_q) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (kind_q == KIND_INSERT) begin
            if (list_full) begin
              status_d   = STATUS_FULL;
              position_d = '0;
            end else begin
              // The last entry (or the new value when appending) goes into
              // the first free slot.
              wr.en      = 1'b1;
              wr.addr    = count_q[IDX_W-1:0];
              wr.data    = found_q ? carry_q : value_q;
              status_d   = STATUS_DONE;
              position_d = found_q ? CNT_W'(pos_q) : count_q;
              count_d    = count_q + CNT_W'(1);
            end
          end else begin
            if (found_q) begin
              status_d   = STATUS_DONE;
              position_d = CNT_W'(pos_q);
              count_d    = count_q - CNT_W'(1);
            end else begin
              status_d   = STATUS_NOT_FOUND;
              position_d = '0;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_idx_q     <= '0;
      rvalid_q     <= 1'b0;
      found_q      <= 1'b0;
      count_q      <= '0;
      order_mode_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      rvalid_q    <= rvalid_d;
      found_q     <= found_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        order_mode_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
    pidx_q     <= pidx_d;
    pos_q      <= pos_d;
    carry_q    <= carry_d;
    status_q   <= status_d;
    position_q <= position_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign position_o    = position_q;
  assign entry_count_o = count_q;
  assign is_full_o     = list_full;
  assign is_empty_o    = (count_q == '0);

  // The count never goes past the list depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LIST_DEPTH))
    else $error("entry count exceeds list depth");

  // A refused insert reports position zero and a full list.
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_FULL |-> position_o == '0 && is_full_o)
    else $error("full status without full flag or with a position");

  // An input transfer always starts work on the next cycle.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != ST_IDLE)
    else $error("input transfer did not start an operation");

  // The walk never reads beyond the stored entries.
  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd.en |-> CNT_W'(rd.addr) < count_q)
    else $error("read beyond stored entries");

endmodule

`default_nettype wire

FILE: sv/sli_ram.sv
// ----------------------------------------------------------------------------
// Sorted list entry memory
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_ram import sli_pkg::*; (
  input  wire logic                   clk_i,
  input  wire sli_wr_t                wr_i,
  input  wire sli_rd_t                rd_i,
  output      logic [VALUE_WIDTH-1:0] rd_data_o
);

  logic [VALUE_WIDTH-1:0] mem [LIST_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_o <= mem[rd_i.addr];
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_sorted_list_insert_remove_core.sv
// ----------------------------------------------------------------------------
// Sorted list insert/remove core testbench
// Drives insert and remove operations into the core and checks every status
// result against a behavioral copy of the ordered list held in the bench.
// Directed tests cover the value extremes, duplicates, missing values, and
// the empty and full list. Random phases in both order modes follow; most
// have idle bursts on both channels, two, the final stretch among them, none.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_list_insert_remove_core;
  import sli_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // No-transfer cycles before the run is declared hung. An operation, a stall
  // burst and an idle burst each have a bounded length.
  localparam int unsigned HANG_LIMIT = 1000;
  // Cycles allowed after the last result before the core counts as idle.
  localparam int unsigned SETTLE_CYCLES = 25;

  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    position;
    logic [CNT_W-1:0]    entry_count;
    logic                is_full;
    logic                is_empty;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          cfg_we_i    = 1'b0;
  logic                          cfg_wdata_i = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic                          kind_i      = KIND_INSERT;
  logic signed [VALUE_WIDTH-1:0] value_i     = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [STATUS_W-1:0]           status_o;
  logic [CNT_W-1:0]              position_o;
  logic [CNT_W-1:0]              entry_count_o;
  logic                          is_full_o;
  logic                          is_empty_o;

  // Bench copy of the list: contents, fill level and order mode.
  logic signed [VALUE_WIDTH-1:0] shadow_list [LIST_DEPTH];
  int                            shadow_count = 0;
  logic                          order_descending = 1'b0;

  // Results predicted for accepted operations, oldest first.
  list_result_t expected_results [$];

  int  error_count = 0;
  bit  idling_on   = 1'b1;
  int  stall_left  = 0;
  int  quiet_cycles = 0;

  sorted_list_insert_remove_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o),
    .is_full_o     (is_full_o),
    .is_empty_o    (is_empty_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Applies one operation to the bench list and returns the status result
  // the core must report for it. An insert goes before the first entry that
  // satisfies the order predicate, so a duplicate lands after its equals.
  function automatic list_result_t predict_list_op(input logic kind,
                                                   input logic signed [VALUE_WIDTH-1:0] value);
    list_result_t res;
    int slot;
    bit hit;
    res.status = STATUS_DONE;
    slot = 0;
    hit = 1'b0;
    if (kind == KIND_INSERT) begin
      if (shadow_count >= LIST_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        slot = shadow_count;
        for (int i = 0; i < shadow_count && !hit; i++) begin
          if (order_descending ? (shadow_list[i] < value) : (shadow_list[i] > value)) begin
            slot = i;
            hit = 1'b1;
          end
        end
        for (int i = shadow_count; i > slot; i--) begin
          shadow_list[i] = shadow_list[i-1];
        end
        shadow_list[slot] = value;
        shadow_count++;
      end
    end else begin
      for (int i = 0; i < shadow_count && !hit; i++) begin
        if (shadow_list[i] == value) begin
          slot = i;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        res.status = STATUS_NOT_FOUND;
        slot = 0;
      end else begin
        for (int i = slot; i + 1 < shadow_count; i++) begin
          shadow_list[i] = shadow_list[i+1];
        end
        shadow_count--;
      end
    end
    res.position    = slot[CNT_W-1:0];
    res.entry_count = shadow_count[CNT_W-1:0];
    res.is_full     = (shadow_count == LIST_DEPTH);
    res.is_empty    = (shadow_count == 0);
    return res;
  endfunction

  // Presents one operation and waits for its transfer. Valid is left high on
  // return: the caller either sends the next operation in the same step or
  // lowers valid through wait_until_drained.
  task automatic send_op(input logic kind, input logic signed [VALUE_WIDTH-1:0] value);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_list_op(kind, value));
  endtask

  // Stops sending and waits until every predicted result has been seen,
  // then gives the core time to finish any internal bookkeeping.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the order mode register; only called while the core is idle.
  task automatic write_order_mode(input logic descending);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= descending;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    order_descending = descending;
    @(posedge clk_i);
  endtask

  // Random data value: small values for frequent duplicates, the ends of the
  // signed range, -1 and 0, or a fully random word.
  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    logic signed [VALUE_WIDTH-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $signed($urandom_range(0, 16)) - 8;
      1: begin
        case ($urandom_range(0, 5))
          0: v = VALUE_MIN;
          1: v = VALUE_MIN + 1;
          2: v = VALUE_MAX;
          3: v = VALUE_MAX - 1;
          4: v = -1;
          default: v = 0;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Remove value: mostly one that is stored, so removes actually shift the
  // list, and otherwise a random one that is usually missing.
  function automatic logic signed [VALUE_WIDTH-1:0] pick_remove_value();
    if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
      return shadow_list[$urandom_range(0, shadow_count - 1)];
    end
    return pick_value();
  endfunction

  // Extremes, duplicates and missing values in ascending order, starting
  // with a remove on the empty list.
  task automatic test_directed_ascending();
    write_order_mode(1'b0);
    send_op(KIND_REMOVE, 0);
    send_op(KIND_INSERT, 0);
    send_op(KIND_INSERT, VALUE_MIN);
    send_op(KIND_INSERT, VALUE_MAX);
    send_op(KIND_INSERT, -1);
    send_op(KIND_INSERT, 1);
    send_op(KIND_INSERT, 0);
    send_op(KIND_INSERT, VALUE_MAX);
    send_op(KIND_REMOVE, 42);
    send_op(KIND_REMOVE, 0);
    send_op(KIND_REMOVE, VALUE_MIN);
    send_op(KIND_REMOVE, VALUE_MAX);
    send_op(KIND_INSERT, 32'h5555_5555);
    send_op(KIND_INSERT, 32'hAAAA_AAAA);
    wait_until_drained();
  endtask

  // Same kind of sequence with the list kept in descending order.
  task automatic test_directed_descending();
    write_order_mode(1'b1);
    send_op(KIND_INSERT, 3);
    send_op(KIND_INSERT, 7);
    send_op(KIND_INSERT, -5);
    send_op(KIND_INSERT, 7);
    send_op(KIND_INSERT, VALUE_MIN);
    send_op(KIND_INSERT, VALUE_MAX);
    send_op(KIND_REMOVE, 7);
    send_op(KIND_REMOVE, -5);
    send_op(KIND_REMOVE, 12345);
    wait_until_drained();
  endtask

  // Fills the list, pushes inserts against the full list, then empties it
  // and removes once more from the empty list.
  task automatic test_full_list();
    write_order_mode(1'b0);
    while (shadow_count < LIST_DEPTH) send_op(KIND_INSERT, pick_value());
    send_op(KIND_INSERT, pick_value());
    send_op(KIND_INSERT, VALUE_MIN);
    while (shadow_count > 0) begin
      send_op(KIND_REMOVE, shadow_list[$urandom_range(0, shadow_count - 1)]);
    end
    send_op(KIND_REMOVE, VALUE_MAX);
    wait_until_drained();
  endtask

  // Random phase. The mix drifts between growing and shrinking the list so
  // that the fill level sweeps between empty and full many times.
  task automatic test_random_ops(input int n_ops, input logic descending, input bit idle);
    bit growing;
    growing = 1'b1;
    write_order_mode(descending);
    idling_on = idle;
    for (int n = 0; n < n_ops; n++) begin
      if (shadow_count == LIST_DEPTH && $urandom_range(0, 2) == 0) growing = 1'b0;
      if (shadow_count == 0) growing = 1'b1;
      if ($urandom_range(0, 3) == 0 ? growing : ($urandom_range(0, 3) != 0) == growing) begin
        send_op(KIND_INSERT, pick_value());
      end else begin
        send_op(KIND_REMOVE, pick_remove_value());
      end
    end
    // The sender holds off here until every result has come back.
    wait_until_drained();
  endtask

  // Result side: random stall bursts while idling is on.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    list_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d position %0d entry_count %0d",
               status_o, position_o, entry_count_o);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (status_o !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, status_o);
          error_count++;
        end
        if (position_o !== exp_res.position) begin
          $error("position: expected %0d, actual %0d", exp_res.position, position_o);
          error_count++;
        end
        if (entry_count_o !== exp_res.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", exp_res.entry_count, entry_count_o);
          error_count++;
        end
        if (is_full_o !== exp_res.is_full) begin
          $error("is_full: expected %0d, actual %0d", exp_res.is_full, is_full_o);
          error_count++;
        end
        if (is_empty_o !== exp_res.is_empty) begin
          $error("is_empty: expected %0d, actual %0d", exp_res.is_empty, is_empty_o);
          error_count++;
        end
      end
    end
  end

  // Hang detection: too many cycles in a row without a transfer on either
  // channel ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ascending();
    test_directed_descending();
    test_full_list();
    test_random_ops(400, 1'b0, 1'b1);
    test_random_ops(400, 1'b1, 1'b0);
    test_random_ops(400, 1'b1, 1'b1);
    test_random_ops(400, 1'b0, 1'b1);
    // Closing stretch at full rate on both sides.
    test_random_ops(200, 1'b1, 1'b0);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
